[sv/sbm_pkg.sv]
// Shared types, codes and character constants of the serial boot monitor.
package sbm_pkg;

  // Line store geometry
  localparam int SBM_LINE_CHARS = 32;
  localparam int SBM_LEN_W      = $clog2(SBM_LINE_CHARS + 1);

  // Descriptor queue geometry
  localparam int SBM_Q_DEPTH = 4;
  localparam int SBM_Q_PTR_W = $clog2(SBM_Q_DEPTH);
  localparam int SBM_Q_CNT_W = $clog2(SBM_Q_DEPTH + 1);

  // Result word packing
  localparam int SBM_OUT_W = 48;

  // Configuration register indexes and reset values
  localparam logic [1:0]  CFG_LOAD_BASE    = 2'd0;
  localparam logic [1:0]  CFG_MIN_SIZE     = 2'd1;
  localparam logic [1:0]  CFG_MAX_SIZE     = 2'd2;
  localparam logic [31:0] RST_LOAD_BASE    = 32'h0001_0000;
  localparam logic [31:0] RST_MIN_SIZE     = 32'd64;
  localparam logic [31:0] RST_MAX_SIZE     = 32'd1048576;

  // Result kinds
  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  // Event codes
  localparam logic [2:0] EV_HELP     = 3'd0;
  localparam logic [2:0] EV_LOAD     = 3'd1;
  localparam logic [2:0] EV_JUMP     = 3'd2;
  localparam logic [2:0] EV_NOTFOUND = 3'd3;
  localparam logic [2:0] EV_DONE     = 3'd4;

  // Work descriptor opcodes passed from front to back
  localparam logic [2:0] OP_ECHO       = 3'd0;
  localparam logic [2:0] OP_LINE       = 3'd1;
  localparam logic [2:0] OP_OK         = 3'd2;
  localparam logic [2:0] OP_SE         = 3'd3;
  localparam logic [2:0] OP_WRITE      = 3'd4;
  localparam logic [2:0] OP_WRITE_DONE = 3'd5;
  localparam logic [2:0] OP_DONE       = 3'd6;

  // Characters
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_O  = 8'h4F;
  localparam logic [7:0] CH_K  = 8'h4B;

  typedef struct packed {
    logic [31:0] load_base;
    logic [31:0] min_size;
    logic [31:0] max_size;
  } sbm_cfg_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  data;
    logic [31:0] addr;
    logic [2:0]  ev;
  } sbm_desc_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] addr;
    logic [2:0]  ev;
    logic        last;
  } sbm_word_t;

  // Command spellings, one character per position.
  function automatic logic [7:0] sbm_help_chr(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h68;
      2'd1:    ch = 8'h65;
      2'd2:    ch = 8'h6C;
      default: ch = 8'h70;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] sbm_load_chr(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h6C;
      3'd1:    ch = 8'h6F;
      3'd2:    ch = 8'h61;
      3'd3:    ch = 8'h64;
      3'd4:    ch = 8'h69;
      3'd5:    ch = 8'h6D;
      3'd6:    ch = 8'h67;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] sbm_jump_chr(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h6A;
      3'd1:    ch = 8'h75;
      3'd2:    ch = 8'h6D;
      3'd3:    ch = 8'h70;
      3'd4:    ch = 8'h69;
      3'd5:    ch = 8'h6D;
      3'd6:    ch = 8'h67;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[sv/sbm_front.sv]
// Front end: accepts received bytes, tracks the monitor mode and issues work descriptors.
module sbm_front
  import sbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_accept,
  input  logic [7:0] in_byte,
  input  sbm_cfg_t  cfg,
  output logic      push,
  output sbm_desc_t desc
);

  localparam logic [1:0] MODE_SHELL   = 2'd0;
  localparam logic [1:0] MODE_HEADER  = 2'd1;
  localparam logic [1:0] MODE_PAYLOAD = 2'd2;

  logic [1:0]           mode_r, mode_nxt;
  logic [SBM_LEN_W-1:0] len_r, len_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 m_help_r, m_help_nxt;
  logic                 m_load_r, m_load_nxt;
  logic                 m_jump_r, m_jump_nxt;
  logic [1:0]           hdr_idx_r, hdr_idx_nxt;
  logic [31:0]          size_r, size_nxt;
  logic [31:0]          left_r, left_nxt;
  logic [31:0]          addr_r, addr_nxt;
  logic [31:0]          gathered;

  // Header bytes land in their little-endian lane.
  assign gathered = size_r | (32'(in_byte) << {hdr_idx_r, 3'b000});

  // Mode handling and descriptor generation
  always_comb begin
    mode_nxt    = mode_r;
    len_nxt     = len_r;
    ovf_nxt     = ovf_r;
    m_help_nxt  = m_help_r;
    m_load_nxt  = m_load_r;
    m_jump_nxt  = m_jump_r;
    hdr_idx_nxt = hdr_idx_r;
    size_nxt    = size_r;
    left_nxt    = left_r;
    addr_nxt    = addr_r;
    push        = 1'b0;
    desc        = '0;
    if (in_accept) begin
      unique case (mode_r)
        MODE_HEADER: begin
          hdr_idx_nxt = hdr_idx_r + 2'd1;
          size_nxt    = gathered;
          if (hdr_idx_r == 2'd3) begin
            push     = 1'b1;
            size_nxt = '0;
            if (gathered < cfg.min_size || gathered > cfg.max_size) begin
              desc.op = OP_SE;
            end else begin
              desc.op  = OP_OK;
              mode_nxt = MODE_PAYLOAD;
              left_nxt = gathered;
              addr_nxt = cfg.load_base;
            end
          end
        end
        MODE_PAYLOAD: begin
          push = 1'b1;
          if (left_r == '0) begin
            desc.op  = OP_DONE;
            mode_nxt = MODE_SHELL;
          end else begin
            desc.data = in_byte;
            desc.addr = addr_r;
            addr_nxt  = addr_r + 32'd1;
            left_nxt  = left_r - 32'd1;
            if (left_r == 32'd1) begin
              desc.op  = OP_WRITE_DONE;
              mode_nxt = MODE_SHELL;
            end else begin
              desc.op = OP_WRITE;
            end
          end
        end
        default: begin
          // Shell mode; the unused mode code behaves the same way.
          push      = 1'b1;
          desc.data = in_byte;
          if (in_byte == CH_LF) begin
            desc.op = OP_LINE;
            if (!ovf_r && len_r == SBM_LEN_W'(4) && m_help_r) begin
              desc.ev = EV_HELP;
            end else if (!ovf_r && len_r == SBM_LEN_W'(7) && m_load_r) begin
              desc.ev     = EV_LOAD;
              mode_nxt    = MODE_HEADER;
              hdr_idx_nxt = 2'd0;
              size_nxt    = '0;
            end else if (!ovf_r && len_r == SBM_LEN_W'(7) && m_jump_r) begin
              desc.ev   = EV_JUMP;
              desc.addr = cfg.load_base;
            end else begin
              desc.ev = EV_NOTFOUND;
            end
            len_nxt    = '0;
            ovf_nxt    = 1'b0;
            m_help_nxt = 1'b1;
            m_load_nxt = 1'b1;
            m_jump_nxt = 1'b1;
          end else if (len_r < SBM_LEN_W'(SBM_LINE_CHARS)) begin
            // Stored byte: keep a running prefix match against each command.
            desc.op    = OP_ECHO;
            m_help_nxt = m_help_r && (len_r < SBM_LEN_W'(4)) &&
                         (in_byte == sbm_help_chr(len_r[1:0]));
            m_load_nxt = m_load_r && (len_r < SBM_LEN_W'(7)) &&
                         (in_byte == sbm_load_chr(len_r[2:0]));
            m_jump_nxt = m_jump_r && (len_r < SBM_LEN_W'(7)) &&
                         (in_byte == sbm_jump_chr(len_r[2:0]));
            len_nxt    = len_r + SBM_LEN_W'(1);
          end else begin
            desc.op = OP_ECHO;
            ovf_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_SHELL;
      len_r     <= '0;
      ovf_r     <= 1'b0;
      m_help_r  <= 1'b1;
      m_load_r  <= 1'b1;
      m_jump_r  <= 1'b1;
      hdr_idx_r <= '0;
      size_r    <= '0;
      left_r    <= '0;
      addr_r    <= '0;
    end else begin
      mode_r    <= mode_nxt;
      len_r     <= len_nxt;
      ovf_r     <= ovf_nxt;
      m_help_r  <= m_help_nxt;
      m_load_r  <= m_load_nxt;
      m_jump_r  <= m_jump_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      size_r    <= size_nxt;
      left_r    <= left_nxt;
      addr_r    <= addr_nxt;
    end
  end

  // The line length never passes the store size.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= SBM_LEN_W'(SBM_LINE_CHARS))
    else $error("line length beyond store size");

  // Payload mode is left exactly when the byte count reaches zero.
  a_payload_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_PAYLOAD && mode_nxt == MODE_SHELL) |-> (left_nxt == '0))
    else $error("payload mode left with bytes outstanding");

endmodule

[sv/sbm_queue.sv]
// Short descriptor queue between front and back end.
module sbm_queue
  import sbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sbm_desc_t push_desc,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output sbm_desc_t head
);

  sbm_desc_t              slot_r [SBM_Q_DEPTH];
  logic [SBM_Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [SBM_Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [SBM_Q_CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == SBM_Q_CNT_W'(SBM_Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + SBM_Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + SBM_Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + SBM_Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - SBM_Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Descriptor storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("descriptor pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("descriptor popped from an empty queue");

endmodule

[sv/sbm_back.sv]
// Back end: expands each descriptor into one to four result words.
module sbm_back
  import sbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  sbm_desc_t head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output sbm_word_t out_word
);

  logic [1:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  sbm_word_t  word_r;
  sbm_word_t  word;
  logic       load;

  assign out_valid = out_valid_r;
  assign out_word  = word_r;
  assign load      = head_valid && (!out_valid_r || out_ready);
  assign pop       = load && word.last;

  // Word for the current step of the head descriptor
  always_comb begin
    word = '0;
    unique case (head.op) inside
      OP_ECHO: begin
        word.kind = KIND_TX;
        word.data = head.data;
        word.last = 1'b1;
      end
      OP_LINE: begin
        case (step_r)
          2'd0: begin
            word.kind = KIND_TX;
            word.data = CH_LF;
          end
          2'd1: begin
            word.kind = KIND_TX;
            word.data = CH_CR;
          end
          default: begin
            word.kind = KIND_EVENT;
            word.addr = head.addr;
            word.ev   = head.ev;
            word.last = 1'b1;
          end
        endcase
      end
      OP_OK, OP_SE: begin
        word.kind = KIND_TX;
        case (step_r)
          2'd0:    word.data = (head.op == OP_OK) ? CH_O : CH_S;
          2'd1:    word.data = (head.op == OP_OK) ? CH_K : CH_E;
          2'd2:    word.data = CH_CR;
          default: begin
            word.data = CH_LF;
            word.last = 1'b1;
          end
        endcase
      end
      OP_WRITE: begin
        word.kind = KIND_WRITE;
        word.data = head.data;
        word.addr = head.addr;
        word.last = 1'b1;
      end
      OP_WRITE_DONE: begin
        if (step_r == 2'd0) begin
          word.kind = KIND_WRITE;
          word.data = head.data;
          word.addr = head.addr;
        end else begin
          word.kind = KIND_EVENT;
          word.ev   = EV_DONE;
          word.last = 1'b1;
        end
      end
      OP_DONE: begin
        word.kind = KIND_EVENT;
        word.ev   = EV_DONE;
        word.last = 1'b1;
      end
      default: begin
        word.last = 1'b1;
      end
    endcase
  end

  // Step counter and output register control
  always_comb begin
    step_nxt = step_r;
    if (load) begin
      step_nxt = word.last ? 2'd0 : step_r + 2'd1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word;
    end
  end

  // A multi-word descriptor keeps its place until its final word is loaded.
  a_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && !load) |=> $stable(step_r))
    else $error("step advanced without loading a word");

  a_event_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && word_r.kind == KIND_EVENT) |-> (word_r.data == '0))
    else $error("event word carries a data byte");

endmodule

[sv/serial_boot_monitor.sv]
// Top level of the serial boot monitor: configuration registers, front, queue and back end.
//
//  Channel | Direction | Handshake             | Payload
//  in_     | input     | in_tvalid/in_tready   | tdata = rx_byte
//  out_    | output    | out_tvalid/out_tready | tdata, tuser = kind, tlast = last
//  cfg_    | input     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One input word is taken per cycle while the four-entry descriptor queue has room.
// Each input word yields zero to four result words; the back end sends one per cycle
// while out_tready is high, through the single-word output register.
// An input word's descriptor is written into the queue, and its first result word is then
// loaded from the queue head into the output register before out_tvalid offers it.
// Reset is synchronous and clears mode, line tracking, counters and queue; no clearing pass.
// An output stall backs up into the queue and then holds in_tready low.
module serial_boot_monitor
  import sbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] rx_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SBM_OUT_W-1:0] out_tdata,  // [7:0] byte_value, [39:8] write_address,
                                           // [42:40] event_code, [47:43] zero
  output logic [1:0]           out_tuser,  // [1:0] kind
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  sbm_cfg_t  cfg_r;
  sbm_desc_t push_desc;
  sbm_desc_t head;
  sbm_word_t out_word;
  logic      in_accept;
  logic      push;
  logic      full;
  logic      head_valid;
  logic      pop;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;
  assign in_accept = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.load_base <= RST_LOAD_BASE;
      cfg_r.min_size  <= RST_MIN_SIZE;
      cfg_r.max_size  <= RST_MAX_SIZE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOAD_BASE: cfg_r.load_base <= cfg_data;
        CFG_MIN_SIZE:  cfg_r.min_size  <= cfg_data;
        CFG_MAX_SIZE:  cfg_r.max_size  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sbm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_byte   (in_tdata),
    .cfg       (cfg_r),
    .push      (push),
    .desc      (push_desc)
  );

  sbm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  sbm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_word   (out_word)
  );

  // Result word packing
  assign out_tdata = {5'b0, out_word.ev, out_word.addr, out_word.data};
  assign out_tuser = out_word.kind;
  assign out_tlast = out_word.last;

endmodule
